@@ src/lssc_pkg.sv @@
// ----------------------------------------------------------------------------
// Lidar scan space classifier package
// Shared widths, class codes, limits and the per-scan summary passed from the
// accumulator stage to the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package lssc_pkg;

  // Largest number of samples that one scan may contribute.
  localparam int unsigned MAX_SAMPLES = 4096;

  localparam int unsigned RANGE_W = 16;
  localparam int unsigned COUNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned TOTAL_W = $clog2(MAX_SAMPLES * 65535 + 1);

  // Field widths of the result item.
  localparam int unsigned CLASS_W         = 3;
  localparam int unsigned VALID_SAMPLES_W = 13;

  localparam int unsigned CFG_INDEX_W = 1;

  // Classification thresholds in millimetres.
  localparam logic [RANGE_W-1:0] NEAR_LIMIT_MM    = RANGE_W'(800);
  localparam logic [RANGE_W-1:0] DISTANT_LIMIT_MM = RANGE_W'(2000);
  localparam logic [RANGE_W-1:0] TIGHT_MIN_MM     = RANGE_W'(600);
  localparam logic [RANGE_W-1:0] OPEN_MAX_MM      = RANGE_W'(3000);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RANGE_FLOOR   = 1'd0,
    REG_RANGE_CEILING = 1'd1
  } cfg_reg_t;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_UNKNOWN = 3'd0,
    CLASS_ROOM    = 3'd1,
    CLASS_HALLWAY = 3'd2,
    CLASS_DOORWAY = 3'd3,
    CLASS_NARROW  = 3'd4
  } space_class_t;

  // Final accumulator values of one scan.
  typedef struct packed {
    logic [COUNT_W-1:0] valid_count;
    logic [COUNT_W-1:0] near_count;
    logic [COUNT_W-1:0] distant_count;
    logic [RANGE_W-1:0] least_range;
    logic [RANGE_W-1:0] greatest_range;
    logic [TOTAL_W-1:0] range_total;
    logic               overflow_seen;
  } scan_summary_t;

endpackage

`default_nettype wire

@@ src/lidar_scan_space_classifier.sv @@
// ----------------------------------------------------------------------------
// Lidar scan space classifier
// Accumulates valid range samples of a scan and emits one space class at the
// end of each scan.
// ----------------------------------------------------------------------------
// The block takes one range sample per clock cycle, unless its input is held as
// described below, and returns one result per scan. A scan's last sample moves
// from the input register into the accumulators and the scan snapshot, and then
// through the classifier into the result register. Each sample only updates
// running counters, the least and greatest range and the range sum, so the
// block keeps a rate of one sample per cycle. A scan's last sample waits in
// the input register only while an earlier scan's snapshot cannot move on.
// Samples beyond the per-scan limit are dropped and flagged in the result.
// Range limits should be written only while no scan is in flight.
`default_nettype none

module lidar_scan_space_classifier
  import lssc_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst,
  // Configuration write channel.
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [CFG_INDEX_W-1:0]     cfg_index,
  input  wire [RANGE_W-1:0]         cfg_data,
  // Sample stream.
  input  wire                       s_tvalid,
  output logic                      s_tready,
  input  wire [15:0]                s_tdata,   // [15:0] range_mm
  input  wire                       s_tuser,   // [0] not_finite
  input  wire                       s_tlast,   // scan_end
  // Result stream.
  output logic                      m_tvalid,
  input  wire                       m_tready,
  output logic [15:0]               m_tdata,   // [2:0] space_class, [15:3] valid_samples
  output logic                      m_tuser    // [0] scan_overflow
);

  // Configuration registers.
  logic [RANGE_W-1:0] range_floor;
  logic [RANGE_W-1:0] range_ceiling;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_floor   <= '0;
      range_ceiling <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_RANGE_FLOOR:   range_floor   <= cfg_data;
        REG_RANGE_CEILING: range_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  logic               in_valid;
  logic [RANGE_W-1:0] in_range;
  logic               in_bad;
  logic               in_last;

  // Pipeline flow control.
  logic snap_valid;
  logic out_ready;
  logic snap_ready;
  logic in_move;

  assign out_ready  = !m_tvalid || m_tready;
  assign snap_ready = !snap_valid || out_ready;
  assign in_move    = in_valid && (!in_last || snap_ready);
  assign s_tready   = !in_valid || in_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_range <= s_tdata[RANGE_W-1:0];
      in_bad   <= s_tuser;
      in_last  <= s_tlast;
    end
  end

  // Scan accumulators.
  logic [COUNT_W-1:0] sample_count;
  logic [COUNT_W-1:0] valid_count;
  logic [COUNT_W-1:0] near_count;
  logic [COUNT_W-1:0] distant_count;
  logic [RANGE_W-1:0] least_range;
  logic [RANGE_W-1:0] greatest_range;
  logic [TOTAL_W-1:0] range_total;
  logic               overflow_seen;

  logic               scan_full;
  logic               sample_ok;
  logic [COUNT_W-1:0] sample_count_next;
  scan_summary_t      summary_next;

  assign scan_full = (sample_count >= COUNT_W'(MAX_SAMPLES));
  assign sample_ok = !scan_full && !in_bad &&
                     (in_range >= range_floor) && (in_range <= range_ceiling);

  always_comb begin
    sample_count_next            = scan_full ? sample_count : sample_count + 1'b1;
    summary_next.overflow_seen   = overflow_seen || scan_full;
    summary_next.valid_count     = valid_count;
    summary_next.near_count      = near_count;
    summary_next.distant_count   = distant_count;
    summary_next.least_range     = least_range;
    summary_next.greatest_range  = greatest_range;
    summary_next.range_total     = range_total;
    if (sample_ok) begin
      summary_next.valid_count = valid_count + 1'b1;
      if (in_range < least_range) begin
        summary_next.least_range = in_range;
      end
      if (in_range > greatest_range) begin
        summary_next.greatest_range = in_range;
      end
      summary_next.range_total = range_total + TOTAL_W'(in_range);
      if (in_range < NEAR_LIMIT_MM) begin
        summary_next.near_count = near_count + 1'b1;
      end else if (in_range >= DISTANT_LIMIT_MM) begin
        summary_next.distant_count = distant_count + 1'b1;
      end
    end
  end

  // The last sample of a scan goes into the snapshot and the accumulators
  // start over for the next scan.
  always_ff @(posedge clk) begin
    if (rst || (in_move && in_last)) begin
      sample_count   <= '0;
      valid_count    <= '0;
      near_count     <= '0;
      distant_count  <= '0;
      least_range    <= '1;
      greatest_range <= '0;
      range_total    <= '0;
      overflow_seen  <= 1'b0;
    end else if (in_move) begin
      sample_count   <= sample_count_next;
      valid_count    <= summary_next.valid_count;
      near_count     <= summary_next.near_count;
      distant_count  <= summary_next.distant_count;
      least_range    <= summary_next.least_range;
      greatest_range <= summary_next.greatest_range;
      range_total    <= summary_next.range_total;
      overflow_seen  <= summary_next.overflow_seen;
    end
  end

  // Snapshot of a finished scan.
  scan_summary_t snap;

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_move && in_last) begin
      snap_valid <= 1'b1;
    end else if (out_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move && in_last) begin
      snap <= summary_next;
    end
  end

  space_class_t snap_class;

  lssc_classify u_classify (
    .summary     (snap),
    .space_class (snap_class)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && snap_valid) begin
      m_tdata <= {VALID_SAMPLES_W'(snap.valid_count), snap_class};
      m_tuser <= snap.overflow_seen;
    end
  end

  // Checks on the accumulator bookkeeping.
  property p_valid_le_samples;
    @(posedge clk) disable iff (rst) valid_count <= sample_count;
  endproperty
  a_valid_le_samples: assert property (p_valid_le_samples)
    else $error("valid sample count exceeds sample count");

  property p_bins_le_valid;
    @(posedge clk) disable iff (rst)
      (COUNT_W + 1)'(near_count) + (COUNT_W + 1)'(distant_count) <= (COUNT_W + 1)'(valid_count);
  endproperty
  a_bins_le_valid: assert property (p_bins_le_valid)
    else $error("near and distant counts exceed valid count");

  property p_empty_extremes;
    @(posedge clk) disable iff (rst)
      (valid_count == '0) |-> (least_range == '1 && greatest_range == '0 && range_total == '0);
  endproperty
  a_empty_extremes: assert property (p_empty_extremes)
    else $error("extremes or sum changed without a valid sample");

  property p_overflow_only_full;
    @(posedge clk) disable iff (rst)
      overflow_seen |-> (sample_count == COUNT_W'(MAX_SAMPLES));
  endproperty
  a_overflow_only_full: assert property (p_overflow_only_full)
    else $error("overflow flagged before the scan limit was reached");

  property p_snapshot_loaded;
    @(posedge clk) disable iff (rst)
      (in_move && in_last) |=> snap_valid;
  endproperty
  a_snapshot_loaded: assert property (p_snapshot_loaded)
    else $error("scan end did not produce a snapshot");

endmodule

`default_nettype wire

@@ src/lssc_classify.sv @@
// ----------------------------------------------------------------------------
// Scan classifier
// Sorts one finished scan into a space class. Ratio and mean tests are done
// as integer cross-multiplications by small constants.
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_classify
  import lssc_pkg::*;
(
  input  wire scan_summary_t summary,
  output space_class_t       space_class
);

  localparam int unsigned RATIO_W = COUNT_W + 4;
  localparam int unsigned MEAN_W  = (TOTAL_W > COUNT_W + 11) ? TOTAL_W : COUNT_W + 11;

  logic [RATIO_W-1:0] near_x10;
  logic [RATIO_W-1:0] distant_x10;
  logic [RATIO_W-1:0] n_x7;
  logic [RATIO_W-1:0] n_x4;
  logic [RATIO_W-1:0] n_x3;
  logic [RATIO_W-1:0] n_x2;
  logic [MEAN_W-1:0]  n_x1000;
  logic [MEAN_W-1:0]  n_x1500;
  logic [MEAN_W-1:0]  total_ext;

  assign near_x10    = RATIO_W'(summary.near_count) * RATIO_W'(10);
  assign distant_x10 = RATIO_W'(summary.distant_count) * RATIO_W'(10);
  assign n_x7        = RATIO_W'(summary.valid_count) * RATIO_W'(7);
  assign n_x4        = RATIO_W'(summary.valid_count) * RATIO_W'(4);
  assign n_x3        = RATIO_W'(summary.valid_count) * RATIO_W'(3);
  assign n_x2        = RATIO_W'(summary.valid_count) * RATIO_W'(2);
  assign n_x1000     = MEAN_W'(summary.valid_count) * MEAN_W'(1000);
  assign n_x1500     = MEAN_W'(summary.valid_count) * MEAN_W'(1500);
  assign total_ext   = MEAN_W'(summary.range_total);

  always_comb begin
    if (summary.valid_count == '0) begin
      space_class = CLASS_UNKNOWN;
    end else if (summary.least_range < TIGHT_MIN_MM && near_x10 > n_x7) begin
      space_class = (total_ext < n_x1000) ? CLASS_NARROW : CLASS_DOORWAY;
    end else if (distant_x10 > n_x3 && summary.greatest_range > OPEN_MAX_MM) begin
      space_class = CLASS_ROOM;
    end else if (near_x10 > n_x4 && total_ext < n_x1500) begin
      space_class = CLASS_HALLWAY;
    end else if (distant_x10 > n_x2) begin
      space_class = CLASS_ROOM;
    end else begin
      space_class = CLASS_HALLWAY;
    end
  end

endmodule

`default_nettype wire

@@ bench/lidar_scan_space_classifier_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lidar scan space classifier testbench
// Streams range samples into the classifier, predicts the class, the valid
// sample count and the overflow flag of every scan, and compares each result
// transaction with the oldest prediction. Directed scans cover the extremes
// and every class. Random scans with biased range mixes then run under
// several range limit settings, with random idling on both streams and one
// long receiver stall.
// ----------------------------------------------------------------------------

module lidar_scan_space_classifier_test;
  import lssc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned PRINT_LIMIT = 50;

  typedef struct packed {
    space_class_t               cls;
    logic [VALID_SAMPLES_W-1:0] count;
    logic                       ovf;
  } scan_result_t;

  class scan_scoreboard;
    bit [RANGE_W-1:0] floor_mm;
    bit [RANGE_W-1:0] ceiling_mm;
    bit [COUNT_W-1:0] taken;
    bit [COUNT_W-1:0] valid_n;
    bit [COUNT_W-1:0] near_n;
    bit [COUNT_W-1:0] distant_n;
    bit [RANGE_W-1:0] least;
    bit [RANGE_W-1:0] greatest;
    bit [TOTAL_W-1:0] total;
    bit               overflow;
    scan_result_t     pending[$];
    int unsigned      errors;

    function new();
      floor_mm = '0;
      ceiling_mm = '1;
      errors = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      taken = '0;
      valid_n = '0;
      near_n = '0;
      distant_n = '0;
      least = '1;
      greatest = '0;
      total = '0;
      overflow = 1'b0;
    endfunction

    function void write_reg(cfg_reg_t idx, bit [RANGE_W-1:0] value);
      case (idx)
        REG_RANGE_FLOOR: floor_mm = value;
        REG_RANGE_CEILING: ceiling_mm = value;
        default: ;
      endcase
    endfunction

    function space_class_t classify_space();
      longint unsigned n;
      longint unsigned nr;
      longint unsigned ds;
      longint unsigned sum;
      n = 64'(valid_n);
      nr = 64'(near_n);
      ds = 64'(distant_n);
      sum = 64'(total);
      if (n == 0) return CLASS_UNKNOWN;
      if (least < TIGHT_MIN_MM && nr * 10 > n * 7)
        return (sum < n * 1000) ? CLASS_NARROW : CLASS_DOORWAY;
      if (ds * 10 > n * 3 && greatest > OPEN_MAX_MM) return CLASS_ROOM;
      if (nr * 10 > n * 4 && sum < n * 1500) return CLASS_HALLWAY;
      if (ds * 10 > n * 2) return CLASS_ROOM;
      return CLASS_HALLWAY;
    endfunction

    function void note_sample(bit [RANGE_W-1:0] r, bit bad, bit last);
      scan_result_t res;
      // Samples past the per-scan limit only raise the overflow flag.
      if (taken >= MAX_SAMPLES) begin
        overflow = 1'b1;
      end else begin
        taken++;
        if (!bad && r >= floor_mm && r <= ceiling_mm) begin
          valid_n++;
          if (r < least) least = r;
          if (r > greatest) greatest = r;
          total += TOTAL_W'(r);
          if (r < NEAR_LIMIT_MM) near_n++;
          else if (r >= DISTANT_LIMIT_MM) distant_n++;
        end
      end
      if (last) begin
        res.cls = classify_space();
        res.count = valid_n;
        res.ovf = overflow;
        pending = {pending, res};
        clear_scan();
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [15:0] data, logic ovf);
      scan_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %h/%b with no scan outstanding", data, ovf));
        return;
      end
      want = pending.pop_front();
      if (data[2:0] !== want.cls)
        report($sformatf("space_class %0d, expected %0d", data[2:0], want.cls));
      if (data[15:3] !== want.count)
        report($sformatf("valid_samples %0d, expected %0d", data[15:3], want.count));
      if (ovf !== want.ovf)
        report($sformatf("scan_overflow %b, expected %b", ovf, want.ovf));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_reg_t         cfg_index = REG_RANGE_FLOOR;
  logic [RANGE_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [15:0]      s_tdata = '0;   // [15:0] range_mm
  logic             s_tuser = 1'b0; // [0] not_finite
  logic             s_tlast = 1'b0; // scan_end
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [15:0]      m_tdata;        // [2:0] space_class, [15:3] valid_samples
  logic             m_tuser;        // [0] scan_overflow

  scan_scoreboard   sb = new();
  int unsigned      cycle_count = 0;
  int unsigned      squeeze_count = 0;
  bit               sender_steady = 1'b0;
  bit [RANGE_W-1:0] cur_floor = '0;
  bit [RANGE_W-1:0] cur_ceiling = '1;

  lidar_scan_space_classifier uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Results are checked ahead of new samples; a result never depends on a
  // sample accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (s_tvalid && s_tready) sb.note_sample(s_tdata, s_tuser, s_tlast);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Result receiver: ready runs broken by stalls, plus one long hold-off on
  // request so that the block backs up into its input.
  initial begin : receiver
    int unsigned run;
    int unsigned stall;
    int unsigned served;
    served = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      m_tready <= 1'b1;
      repeat (run) @(negedge clk);
      case ($urandom_range(0, 19))
        0:       stall = $urandom_range(20, 60);
        1, 2, 3: stall = 0;
        default: stall = $urandom_range(1, 3);
      endcase
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      if (served != squeeze_count) begin
        served = squeeze_count;
        m_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (sender_steady || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit [RANGE_W-1:0] pick_range(int unsigned band);
    bit [RANGE_W-1:0] edges[14];
    edges = '{cur_floor, cur_ceiling, cur_floor - 16'd1, cur_ceiling + 16'd1, 16'd0,
              16'hFFFF, 16'd599, 16'd600, 16'd799, 16'd800, 16'd1999, 16'd2000,
              16'd3000, 16'd3001};
    case (band)
      0: return RANGE_W'($urandom_range(0, 599));
      1: return RANGE_W'($urandom_range(600, 799));
      2: return RANGE_W'($urandom_range(800, 1999));
      3: return RANGE_W'($urandom_range(2000, 3000));
      4: return RANGE_W'($urandom_range(3001, 65535));
      5: return RANGE_W'($urandom_range(0, 65535));
      default: return edges[4'($urandom_range(0, 13))];
    endcase
  endfunction

  // Drives one sample and returns at the falling edge after its transaction.
  task send_sample(bit [RANGE_W-1:0] r, bit bad, bit last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= r;
    s_tuser <= bad;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Returns at the falling edge that follows the drop of the write strobe.
  task write_reg(cfg_reg_t idx, bit [RANGE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == REG_RANGE_FLOOR) cur_floor = value;
    else cur_ceiling = value;
  endtask

  task settle();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One scan whose samples mostly come from one range band.
  task send_scan(int unsigned len);
    int unsigned i;
    int unsigned band;
    int unsigned purity;
    band = $urandom_range(0, 6);
    purity = $urandom_range(50, 100);
    for (i = 0; i < len; i++)
      send_sample(pick_range(($urandom_range(0, 99) < purity) ? band : $urandom_range(0, 6)),
                  $urandom_range(0, 19) == 0, i == len - 1);
  endtask

  task random_scans(int unsigned items);
    int unsigned sent;
    int unsigned len;
    int unsigned roll;
    sent = 0;
    while (sent < items) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) len = $urandom_range(1, 12);
      else if (roll < 90) len = $urandom_range(13, 60);
      else len = $urandom_range(61, 300);
      sender_steady = ($urandom_range(0, 4) == 0);
      send_scan(len);
      sent += len;
    end
    sender_steady = 1'b0;
  endtask

  initial begin : stimulus
    bit [RANGE_W-1:0] floors[8];
    bit [RANGE_W-1:0] ceilings[8];
    int unsigned p;
    int unsigned i;
    floors = '{16'd0, 16'd0, 16'hFFFF, 16'd5000, 16'd300, 16'd0, 16'd1000, 16'd0};
    ceilings = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd100, 16'd4000, 16'hFFFF, 16'd2999, 16'd0};

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_reg(REG_RANGE_FLOOR, 16'd0);
    write_reg(REG_RANGE_CEILING, 16'hFFFF);

    // Empty scan, then single samples at both range extremes.
    send_sample(16'hFFFF, 1'b1, 1'b1);
    send_sample(16'd0, 1'b0, 1'b1);
    send_sample(16'hFFFF, 1'b0, 1'b1);
    // Tight space with a large mean: doorway.
    send_sample(16'd100, 1'b0, 1'b0);
    send_sample(16'd100, 1'b0, 1'b0);
    send_sample(16'd100, 1'b0, 1'b0);
    send_sample(16'd7000, 1'b0, 1'b1);
    // Mostly near readings without a tight minimum: hallway.
    send_sample(16'd700, 1'b0, 1'b0);
    send_sample(16'd700, 1'b0, 1'b0);
    send_sample(16'd1200, 1'b0, 1'b1);
    // Some distant readings but no open side: room by the weaker test.
    send_sample(16'd2500, 1'b0, 1'b0);
    send_sample(16'd1000, 1'b0, 1'b0);
    send_sample(16'd1000, 1'b0, 1'b0);
    send_sample(16'd1000, 1'b0, 1'b1);
    // Nothing stands out: hallway by default.
    send_sample(16'd1000, 1'b0, 1'b0);
    send_sample(16'd1000, 1'b1, 1'b1);
    // Threshold values themselves.
    send_sample(16'd599, 1'b0, 1'b0);
    send_sample(16'd600, 1'b0, 1'b0);
    send_sample(16'd799, 1'b0, 1'b0);
    send_sample(16'd800, 1'b0, 1'b0);
    send_sample(16'd2000, 1'b0, 1'b0);
    send_sample(16'd3000, 1'b0, 1'b0);
    send_sample(16'd3001, 1'b0, 1'b1);
    settle();

    for (p = 0; p < 8; p++) begin
      if (p >= 6) begin
        floors[p] = RANGE_W'($urandom_range(0, 65535));
        ceilings[p] = RANGE_W'($urandom_range(0, 65535));
      end
      write_reg(REG_RANGE_FLOOR, floors[p]);
      write_reg(REG_RANGE_CEILING, ceilings[p]);
      if (p == 0) begin
        // Back-to-back single-sample scans while the receiver holds off.
        squeeze_count <= squeeze_count + 1;
        sender_steady = 1'b1;
        for (i = 0; i < 40; i++) send_sample(pick_range($urandom_range(0, 6)), 1'b0, 1'b1);
        sender_steady = 1'b0;
      end
      random_scans(200);
      settle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
